// ----- rtl/core/tlge_pkg.sv -----
// Package for the toroidal life grid engine: grid geometry, operation codes,
// sequencer states and the seed pattern. No dependencies.
`default_nettype none

package tlge_pkg;

   localparam int GRID_HEIGHT = 32;
   localparam int GRID_WIDTH  = 32;

   localparam int ROW_W   = GRID_WIDTH;
   localparam int CNT_W   = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int CELLS_W = 32;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_TOGGLE = 2'd1;
   localparam logic [OP_W-1:0] OP_STEP   = 2'd2;

   localparam int SEED_ROW = 3;
   localparam int SEED_COL = 3;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } state_type;

   function automatic logic [ROW_W-1:0] seed_row(input logic [CNT_W-1:0] r);
      logic [ROW_W-1:0] bits;
      bits = ROW_W'(3'b111) << SEED_COL;
      return (r == CNT_W'(SEED_ROW)) ? bits : '0;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tlge_life_row.sv -----
// Row-wide neighbor unit: next generation of one row by the B3/S23 rule
// from the rows above and below, with wrap-around columns. Uses tlge_pkg.
`default_nettype none

module tlge_life_row import tlge_pkg::*; (
   input  logic [ROW_W-1:0] up_row,
   input  logic [ROW_W-1:0] cur_row,
   input  logic [ROW_W-1:0] down_row,
   output logic [ROW_W-1:0] next_row
);

   logic [ROW_W-1:0] nb [8];

   always_comb begin
      nb[0] = up_row;
      nb[1] = {up_row[ROW_W-2:0], up_row[ROW_W-1]};
      nb[2] = {up_row[0], up_row[ROW_W-1:1]};
      nb[3] = {cur_row[ROW_W-2:0], cur_row[ROW_W-1]};
      nb[4] = {cur_row[0], cur_row[ROW_W-1:1]};
      nb[5] = down_row;
      nb[6] = {down_row[ROW_W-2:0], down_row[ROW_W-1]};
      nb[7] = {down_row[0], down_row[ROW_W-1:1]};
   end

   always_comb begin
      logic [3:0] count;
      for (int c = 0; c < ROW_W; c++) begin
         count = '0;
         for (int k = 0; k < 8; k++) begin
            count = count + 4'(nb[k][c]);
         end
         next_row[c] = (count == 4'd3) || (cur_row[c] && (count == 4'd2));
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/toroidal_life_grid_engine_core.sv -----
// Top level of the toroidal life grid engine: row ring, sequencer and
// output register. Uses tlge_pkg and tlge_life_row.
//
//   Channel  Direction  tdata (low bit up)                    tlast     tuser
//   req      in         operation, cell_row, cell_column      -         -
//   rsp      out        row_number, row_cells                 last_row  index_error
//
// Every word on req is accepted while the sequencer is idle; then the row ring
// rotates once, one row per cycle while rsp is not stalled, through the shared row
// unit and into the output. A new word is taken in the cycle after the last
// row has been loaded for output.
// A stalled rsp holds the ring in place; nothing is lost or repeated.
// Reset is synchronous and restores the seeded grid at once.
`default_nettype none

module toroidal_life_grid_engine_core import tlge_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // operation, cell_row, cell_column
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // row_number, row_cells
   output logic                  rsp_tlast,
   output logic [0:0]            rsp_tuser    // index_error
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic             err_ff, err_in;
   logic [ROW_W-1:0] grid_ff [GRID_HEIGHT];
   logic [ROW_W-1:0] grid_in [GRID_HEIGHT];
   logic [ROW_W-1:0] prev_ff, prev_in;
   logic [ROW_W-1:0] first_ff, first_in;
   logic             out_valid_ff, out_valid_in;
   logic [IDX_W-1:0] out_row_ff, out_row_in;
   logic [CELLS_W-1:0] out_cells_ff, out_cells_in;
   logic             out_last_ff, out_last_in;
   logic             out_err_ff, out_err_in;

   logic             accept;
   logic             advance;
   logic             last_count;
   logic [OP_W-1:0]  req_op;
   logic [IDX_W-1:0] req_row;
   logic [IDX_W-1:0] req_col;
   logic             req_bad;
   logic [ROW_W-1:0] up_row, down_row, life_row, new_row;

   assign req_op  = req_tdata[OP_W-1:0];
   assign req_row = req_tdata[OP_W+IDX_W-1:OP_W];
   assign req_col = req_tdata[OP_W+2*IDX_W-1:OP_W+IDX_W];
   assign req_bad = ({1'b0, req_row} >= (IDX_W+1)'(GRID_HEIGHT)) ||
                    ({1'b0, req_col} >= (IDX_W+1)'(GRID_WIDTH));

   assign last_count = (count_ff == CNT_W'(GRID_HEIGHT - 1));

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      advance    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            advance = !out_valid_ff || rsp_tready;
            if (advance && last_count) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   assign up_row   = (count_ff == '0) ? grid_ff[GRID_HEIGHT-1] : prev_ff;
   assign down_row = last_count ? first_ff : grid_ff[1];

   tlge_life_row u_life_row (
      .up_row   (up_row),
      .cur_row  (grid_ff[0]),
      .down_row (down_row),
      .next_row (life_row)
   );

   always_comb begin
      case (op_ff)
         OP_CLEAR: begin
            new_row = seed_row(count_ff);
         end
         OP_TOGGLE: begin
            new_row = grid_ff[0];
            if (!err_ff && (row_ff == IDX_W'(count_ff))) begin
               new_row = grid_ff[0] ^ (ROW_W'(1) << col_ff);
            end
         end
         OP_STEP: begin
            new_row = life_row;
         end
         default: begin
            new_row = grid_ff[0];
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      err_in       = err_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_row_in   = out_row_ff;
      out_cells_in = out_cells_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      for (int i = 0; i < GRID_HEIGHT; i++) begin
         grid_in[i] = grid_ff[i];
      end
      if (accept) begin
         count_in = '0;
         op_in    = req_op;
         row_in   = req_row;
         col_in   = req_col;
         err_in   = (req_op == OP_TOGGLE) && req_bad;
         first_in = grid_ff[0];
      end
      if (advance) begin
         count_in     = count_ff + CNT_W'(1);
         prev_in      = grid_ff[0];
         out_valid_in = 1'b1;
         out_row_in   = IDX_W'(count_ff);
         out_cells_in = CELLS_W'(new_row);
         out_last_in  = last_count;
         out_err_in   = err_ff;
         for (int i = 0; i < GRID_HEIGHT - 1; i++) begin
            grid_in[i] = grid_ff[i+1];
         end
         grid_in[GRID_HEIGHT-1] = new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         op_ff        <= OP_CLEAR;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < GRID_HEIGHT; i++) begin
            grid_ff[i] <= seed_row(CNT_W'(i));
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         op_ff        <= op_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < GRID_HEIGHT; i++) begin
            grid_ff[i] <= grid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      out_row_ff   <= out_row_in;
      out_cells_ff <= out_cells_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {(RSP_DATA_W - IDX_W - CELLS_W)'(0), out_cells_ff, out_row_ff};
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_err_ff;

   // The last-row flag and the row number of a word always agree.
   a_last_matches_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (out_row_ff == IDX_W'(GRID_HEIGHT - 1))))
      else $error("last_row flag disagrees with row number");

   // An accepted word starts a pass at row zero and blocks further input.
   a_accept_starts_pass: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (count_ff == '0) && !req_tready)
      else $error("accepted word did not start a pass");

   // The pass ends right after the last row is loaded for output.
   a_pass_ends: assert property (@(posedge clock) disable iff (reset)
      (advance && last_count) |=> (state_ff == ST_IDLE) && rsp_tvalid && rsp_tlast)
      else $error("pass did not end after the last row");

   // The error flag is only ever raised by a toggle.
   a_err_only_toggle: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (op_ff == OP_TOGGLE))
      else $error("index error without a toggle");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for toroidal_life_grid_engine_core: it drives clear,
// toggle, step and unused-code words, predicts every emitted grid row and checks it.
// Depends on tlge_pkg and the core RTL.
`default_nettype none

module tb import tlge_pkg::*; ();

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RANDOM_WORDS    = 350;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [IDX_W-1:0]   row_number;
      logic [CELLS_W-1:0] row_cells;
      logic               last_row;
      logic               index_error;
   } grid_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic [0:0]            rsp_tuser;

   logic [GRID_WIDTH-1:0] life_grid [GRID_HEIGHT];
   grid_row_type          expected_rows [$];
   int                    mismatch_count = 0;
   int                    hold_requests  = 0;
   bit                    sender_gaps    = 1'b1;

   toroidal_life_grid_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #60_000_000;
      $display("toroidal_life_grid_engine_core verification failed");
      $finish;
   end

   task automatic seed_life_grid();
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         life_grid[r] = '0;
      end
      life_grid[SEED_ROW][SEED_COL +: 3] = 3'b111;
   endtask

   task automatic advance_life_grid();
      logic [GRID_WIDTH-1:0] next_rows [GRID_HEIGHT];
      int neighbors;
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         for (int c = 0; c < GRID_WIDTH; c++) begin
            neighbors = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if (dr != 0 || dc != 0) begin
                     neighbors += life_grid[(r + dr + GRID_HEIGHT) % GRID_HEIGHT]
                                           [(c + dc + GRID_WIDTH) % GRID_WIDTH];
                  end
               end
            end
            next_rows[r][c] = (neighbors == 3) || (life_grid[r][c] && neighbors == 2);
         end
      end
      life_grid = next_rows;
   endtask

   task automatic predict_grid_rows(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                                    input logic [IDX_W-1:0] col);
      logic         bad_index;
      grid_row_type row_word;
      bad_index = 1'b0;
      case (op)
         OP_CLEAR: begin
            seed_life_grid();
         end
         OP_TOGGLE: begin
            if (row < GRID_HEIGHT && col < GRID_WIDTH) begin
               life_grid[row][col] = ~life_grid[row][col];
            end else begin
               bad_index = 1'b1;
            end
         end
         OP_STEP: begin
            advance_life_grid();
         end
         default: begin
         end
      endcase
      for (int r = 0; r < GRID_HEIGHT; r++) begin
         row_word.row_number  = IDX_W'(r);
         row_word.row_cells   = CELLS_W'(life_grid[r]);
         row_word.last_row    = (r == GRID_HEIGHT - 1);
         row_word.index_error = bad_index;
         expected_rows.push_back(row_word);
      end
   endtask

   task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({col, row, op});
      do @(posedge clock); while (!req_tready);
      predict_grid_rows(op, row, col);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col);
      send_word(op, row, col);
      if (sender_gaps) idle_sender(pick_gap());
   endtask

   task automatic send_bad_toggle();
      if ($urandom_range(0, 1) == 0) begin
         send_item(OP_TOGGLE, IDX_W'($urandom_range(GRID_HEIGHT, 63)), IDX_W'($urandom));
      end else begin
         send_item(OP_TOGGLE, IDX_W'($urandom), IDX_W'($urandom_range(GRID_WIDTH, 63)));
      end
   endtask

   task automatic log_mismatch(input string what, input grid_row_type want,
                               input grid_row_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s: want row %0d cells %h last %0b err %0b, got row %0d cells %h last %0b err %0b",
                  what, want.row_number, want.row_cells, want.last_row, want.index_error,
                  got.row_number, got.row_cells, got.last_row, got.index_error);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      grid_row_type got;
      grid_row_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row_number  = rsp_tdata[IDX_W-1:0];
         got.row_cells   = rsp_tdata[IDX_W +: CELLS_W];
         got.last_row    = rsp_tlast;
         got.index_error = rsp_tuser[0];
         if (expected_rows.size() == 0) begin
            log_mismatch("unexpected word", '0, got);
         end else begin
            want = expected_rows.pop_front();
            if (got.row_number !== want.row_number || got.row_cells !== want.row_cells ||
                got.last_row !== want.last_row || got.index_error !== want.index_error) begin
               log_mismatch("row mismatch", want, got);
            end
         end
      end
   end

   initial begin : rsp_stall
      int hold_seen;
      int hold_left;
      int stall_left;
      int mode_left;
      bit steady;
      hold_seen  = 0;
      hold_left  = 0;
      stall_left = 0;
      mode_left  = 0;
      steady     = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            if (mode_left == 0) begin
               steady    = ($urandom_range(0, 2) == 0);
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (!steady && $urandom_range(0, 4) == 0) begin
               rsp_tready <= 1'b0;
               stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // The unused operation code must leave the seeded grid untouched.
   task automatic test_reset_pattern();
      send_item(OP_UNUSED, '1, '1);
   endtask

   task automatic test_corner_toggles();
      send_item(OP_TOGGLE, '0, '0);
      send_item(OP_TOGGLE, '0, IDX_W'(GRID_WIDTH - 1));
      send_item(OP_TOGGLE, IDX_W'(GRID_HEIGHT - 1), '0);
      send_item(OP_TOGGLE, IDX_W'(GRID_HEIGHT - 1), IDX_W'(GRID_WIDTH - 1));
      send_item(OP_TOGGLE, IDX_W'(GRID_HEIGHT - 1), IDX_W'(GRID_WIDTH - 1));
      send_item(OP_TOGGLE, IDX_W'(GRID_HEIGHT), '0);
      send_item(OP_TOGGLE, '0, IDX_W'(GRID_WIDTH));
      send_item(OP_TOGGLE, '1, '1);
   endtask

   task automatic test_blinker();
      send_item(OP_CLEAR, '1, '1);
      send_item(OP_STEP, '0, '0);
      send_item(OP_STEP, '1, '1);
   endtask

   // A glider placed across the corner exercises wrap on both axes.
   task automatic test_wrapping_glider();
      send_item(OP_CLEAR, '0, '0);
      for (int c = 0; c < 3; c++) begin
         send_item(OP_TOGGLE, IDX_W'(SEED_ROW), IDX_W'(SEED_COL + c));
      end
      send_item(OP_TOGGLE, IDX_W'(GRID_HEIGHT - 1), '0);
      send_item(OP_TOGGLE, '0, IDX_W'(1));
      send_item(OP_TOGGLE, IDX_W'(1), IDX_W'(GRID_WIDTH - 1));
      send_item(OP_TOGGLE, IDX_W'(1), '0);
      send_item(OP_TOGGLE, IDX_W'(1), IDX_W'(1));
      repeat (3) send_item(OP_STEP, IDX_W'($urandom), IDX_W'($urandom));
   endtask

   task automatic test_input_backpressure();
      sender_gaps = 1'b0;
      hold_requests++;
      repeat (3) begin
         send_item(OP_TOGGLE, IDX_W'($urandom_range(0, GRID_HEIGHT - 1)),
                   IDX_W'($urandom_range(0, GRID_WIDTH - 1)));
         send_item(OP_STEP, IDX_W'($urandom), IDX_W'($urandom));
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_sequences();
      int sent;
      int pick;
      int base_row;
      int base_col;
      int draws;
      int steps;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         sender_gaps = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            send_item(OP_CLEAR, IDX_W'($urandom), IDX_W'($urandom));
            sent++;
         end else if (pick < 12) begin
            send_bad_toggle();
            sent++;
         end else if (pick < 16) begin
            send_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom));
            sent++;
         end else begin
            base_row = $urandom_range(0, GRID_HEIGHT - 1);
            base_col = $urandom_range(0, GRID_WIDTH - 1);
            draws    = $urandom_range(2, 10);
            steps    = $urandom_range(1, 5);
            repeat (draws) begin
               send_item(OP_TOGGLE, IDX_W'((base_row + $urandom_range(0, 4)) % GRID_HEIGHT),
                         IDX_W'((base_col + $urandom_range(0, 4)) % GRID_WIDTH));
            end
            repeat (steps) send_item(OP_STEP, IDX_W'($urandom), IDX_W'($urandom));
            sent += draws + steps;
         end
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      seed_life_grid();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_pattern();
      test_corner_toggles();
      test_blinker();
      test_wrapping_glider();
      test_input_backpressure();
      test_random_sequences();
      idle_sender(1);
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (2 * GRID_HEIGHT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("toroidal_life_grid_engine_core verification clean");
      end else begin
         $display("toroidal_life_grid_engine_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
